>>> rtl/tcvk_pkg.sv
// Shared types and codes for the triangle count vertex kernel.
// No dependencies; used by tcvk_apply and triangle_count_vertex_kernel.
package tcvk_pkg;

	localparam logic [1:0] REQ_GATHER   = 2'd0;
	localparam logic [1:0] REQ_BARRIER  = 2'd1;
	localparam logic [1:0] REQ_LOAD     = 2'd2;
	localparam logic [1:0] CLOSING_HOPS = 2'd2;
	localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  vertex_index;
		logic [15:0] current_level;
		logic [1:0]  msg_hops;
		logic [15:0] msg_origin;
		logic [15:0] msg_via_first;
		logic [15:0] msg_via_second;
		logic [15:0] load_global_id;
		logic        load_active;
		logic [15:0] load_send_level;
	} req_t;

	typedef struct packed {
		logic        update_valid;
		logic [15:0] upd_origin;
		logic [15:0] upd_via_first;
		logic [15:0] upd_via_second;
		logic [1:0]  upd_hops;
		logic        triangle_found;
		logic [31:0] vertex_triangles;
	} rsp_t;

	// One vertex table entry as held in the RAM.
	typedef struct packed {
		logic [15:0] global_id;
		logic        active;
		logic [15:0] send_level;
		logic [31:0] count;
	} entry_t;

endpackage

>>> rtl/tcvk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module tcvk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tcvk_apply.sv
// Per-request update of one vertex entry: load, gather forward/close, barrier.
// Depends on tcvk_pkg.
module tcvk_apply (
	input  tcvk_pkg::req_t   req,
	input  tcvk_pkg::entry_t ent,
	input  logic             in_range,
	output tcvk_pkg::rsp_t   rsp,
	output logic             wr_en,
	output tcvk_pkg::entry_t wr_ent
);

	always_comb begin
		rsp    = '0;
		wr_en  = 1'b0;
		wr_ent = ent;
		if (in_range) begin
			rsp.vertex_triangles = ent.count;
			unique case (req.req_type)
				tcvk_pkg::REQ_LOAD: begin
					wr_en                = 1'b1;
					wr_ent.global_id     = req.load_global_id;
					wr_ent.active        = req.load_active;
					wr_ent.send_level    = req.load_send_level;
					wr_ent.count         = '0;
					rsp.vertex_triangles = '0;
				end
				tcvk_pkg::REQ_GATHER: begin
					if (req.msg_hops < tcvk_pkg::CLOSING_HOPS) begin
						rsp.update_valid   = 1'b1;
						rsp.upd_origin     = req.msg_origin;
						rsp.upd_via_first  = (req.msg_hops == 2'd0) ? ent.global_id
							: req.msg_via_first;
						rsp.upd_via_second = (req.msg_hops == 2'd1) ? ent.global_id
							: req.msg_via_second;
						rsp.upd_hops       = req.msg_hops + 2'd1;
					end else if (req.msg_hops == tcvk_pkg::CLOSING_HOPS &&
							req.msg_origin == ent.global_id) begin
						rsp.triangle_found = 1'b1;
						if (ent.count != tcvk_pkg::COUNT_MAX) begin
							wr_en                = 1'b1;
							wr_ent.count         = ent.count + 32'd1;
							rsp.vertex_triangles = ent.count + 32'd1;
						end
					end
				end
				tcvk_pkg::REQ_BARRIER: begin
					if (ent.active && req.current_level == ent.send_level) begin
						rsp.update_valid = 1'b1;
						rsp.upd_origin   = ent.global_id;
						wr_en            = 1'b1;
						wr_ent.active    = 1'b0;
					end
				end
				default: begin
					// unused request code: only the count is reported
				end
			endcase
		end
	end

endmodule

>>> rtl/triangle_count_vertex_kernel.sv
// Triangle count vertex kernel: per-vertex gather/apply over a vertex table.
//
// Request channel: a beat on req is taken at a rising edge with start high and
// busy low. busy is set by reset and cleared at the first rising edge after
// reset is released; after that one request can be taken every cycle.
// Result channel: exactly one result per request. done is high for one cycle
// with the result on rsp, registered through req_s1 and then rsp_q/done_q, and
// is taken at the edge ending that cycle. The receiver cannot stall it.
// Throughput: one request per cycle. The vertex table sits in one RAM with a
// registered read; each request reads its entry at acceptance and writes it
// back at the next edge, with the last write forwarded when the next request
// hits the same entry.
// Reset (arst_n low, asynchronous) clears the per-entry written flags, so every
// active flag and count reads as zero; global ids and send levels are
// undefined until an entry is loaded. No clearing pass is needed.
module triangle_count_vertex_kernel #(
	parameter int VERTICES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  tcvk_pkg::req_t   req,
	output logic             done,
	output tcvk_pkg::rsp_t   rsp
);

	localparam int DEPTH = (VERTICES < 256) ? VERTICES : 256;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EW    = $bits(tcvk_pkg::entry_t);

	logic             busy_q;
	logic             accept;
	logic             v_s1;
	tcvk_pkg::req_t   req_s1;
	logic [AW-1:0]    addr_s1;
	logic             in_range_s1;
	logic [EW-1:0]    ram_rdata;
	tcvk_pkg::entry_t raw_ent;
	tcvk_pkg::entry_t cur_ent;
	logic [DEPTH-1:0] written_q;
	logic             fwd_en_q;
	logic [AW-1:0]    fwd_addr_q;
	tcvk_pkg::entry_t fwd_ent_q;
	tcvk_pkg::rsp_t   rsp_next;
	logic             wr_req;
	logic             wr_en;
	tcvk_pkg::entry_t wr_ent;
	logic             done_q;
	tcvk_pkg::rsp_t   rsp_q;

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			v_s1   <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			v_s1   <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	assign addr_s1     = req_s1.vertex_index[AW-1:0];
	assign in_range_s1 = {24'd0, req_s1.vertex_index} < 32'(VERTICES);

	tcvk_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_ent),
		.re    (accept),
		.raddr (req.vertex_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	// RAM returns old data when the previous beat wrote the same entry
	always_comb begin
		raw_ent = tcvk_pkg::entry_t'(ram_rdata);
		if (fwd_en_q && fwd_addr_q == addr_s1) begin
			raw_ent = fwd_ent_q;
		end
		cur_ent = raw_ent;
		if (!written_q[addr_s1]) begin
			cur_ent.active = 1'b0;
			cur_ent.count  = '0;
		end
	end

	tcvk_apply u_apply (
		.req      (req_s1),
		.ent      (cur_ent),
		.in_range (in_range_s1),
		.rsp      (rsp_next),
		.wr_en    (wr_req),
		.wr_ent   (wr_ent)
	);

	assign wr_en = v_s1 && wr_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			fwd_en_q  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[addr_s1] <= 1'b1;
			end
			fwd_en_q <= wr_en;
			done_q   <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_ent_q  <= wr_ent;
		if (v_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
